@@ rtl/vector_l2_normalizer_assert.svh @@
// Assertion macros for the vector L2 normalizer.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef VECTOR_L2_NORMALIZER_ASSERT_SVH
`define VECTOR_L2_NORMALIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VLN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vln assertion failed");
// next-cycle implication
`define VLN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vln assertion failed");
`else
`define VLN_ASSERT_IMPL(lbl, ante, cons)
`define VLN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/vln_pkg.sv @@
// Shared constants and the controller-to-datapath command type.
// No dependencies.
`timescale 1ns / 1ps
package vln_pkg;

  // result format: signed Q1.14
  localparam int OUT_W     = 16;
  localparam int FRAC_BITS = 14;
  // |element| <= length, so the quotient never exceeds 2^FRAC_BITS
  localparam int QUOT_BITS = FRAC_BITS + 1;

  typedef struct packed {
    logic load_elem;
    logic square;
    logic accum;
    logic clear;
    logic root_init;
    logic root_step;
    logic rd_elem;
    logic div_init;
    logic div_step;
    logic emit;
  } vln_cmd_t;

endpackage

@@ rtl/vector_l2_normalizer.sv @@
// Vector L2 normalizer top level: controller plus datapath.
// Depends on vln_pkg, vln_ctrl, vln_dp and vector_l2_normalizer_assert.svh.
//
// Use: drive in_element / in_last_element with start high; the beat is taken
// on a rising edge where busy is low. Elements are signed Q8.8; the beat with
// in_last_element high closes the vector. Beyond MAX_DIM elements, beats are
// dropped and every result of that vector carries out_truncated.
// Each loaded element goes through capture, square and accumulate, with
// the registered squarer ahead of the sum register.
// After the last beat the square root runs, one bit of root per cycle; then
// each element goes through store read, divider load, 15 divide steps and
// the result register.
// Results come out as single-cycle out_valid beats in element order, signed
// Q1.14, with out_last_result on the final one; the receiver cannot stall,
// so it must take each beat when it appears. busy is high while each stored
// beat is squared and summed, and from the last beat to the final result.
// Reset (rst_n low, synchronous) drops any partial vector and clears the sum,
// count and truncation flag; store contents are not cleared.
`timescale 1ns / 1ps
`include "vector_l2_normalizer_assert.svh"
module vector_l2_normalizer #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [ELEM_WIDTH-1:0]     in_element,
  input  logic                             in_last_element,
  output logic                             out_valid,
  output logic signed [vln_pkg::OUT_W-1:0] out_unit_element,
  output logic                             out_last_result,
  output logic                             out_truncated
);

  localparam int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SUM_RAW = 2 * ELEM_WIDTH - 2 + $clog2(MAX_DIM + 1);
  localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
  localparam int ROOT_W  = (SUM_W + 1) / 2;

  vln_pkg::vln_cmd_t cmd;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  vln_ctrl #(.MAX_DIM(MAX_DIM), .ROOT_STEPS(ROOT_W)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_last_element (in_last_element),
    .busy            (busy),
    .cmd             (cmd),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .out_valid       (out_valid),
    .out_last_result (out_last_result),
    .out_truncated   (out_truncated)
  );

  vln_dp #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .SUM_W      (SUM_W),
    .ROOT_W     (ROOT_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .rd_addr          (rd_addr),
    .in_element       (in_element),
    .out_unit_element (out_unit_element)
  );

  // result stays within the unit range
  `VLN_ASSERT_IMPL(a_unit_range, out_valid, (out_unit_element <= 16384) && (out_unit_element >= -16384))
  // an accepted last beat always makes the block busy
  `VLN_ASSERT_NEXT(a_accept_busy, start && !busy && in_last_element, busy)
  // nothing follows the final result of a vector
  `VLN_ASSERT_NEXT(a_last_ends, out_valid && out_last_result, !out_valid)
  // more results pending keeps input closed
  `VLN_ASSERT_IMPL(a_mid_busy, out_valid && !out_last_result, busy)

endmodule

@@ rtl/vln_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vln_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ rtl/vln_ctrl.sv @@
// Controller FSM: load sequencing, root and divide iteration counts, result strobes.
// Depends on vln_pkg.
`timescale 1ns / 1ps
module vln_ctrl #(
  parameter int MAX_DIM    = 64,
  parameter int ROOT_STEPS = 19,
  localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CNT_W = $clog2(MAX_DIM + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_last_element,
  output logic              busy,
  output vln_pkg::vln_cmd_t cmd,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     rd_addr,
  output logic              out_valid,
  output logic              out_last_result,
  output logic              out_truncated
);

  localparam int MAX_IT = (ROOT_STEPS > vln_pkg::QUOT_BITS) ? ROOT_STEPS : vln_pkg::QUOT_BITS;
  localparam int IT_W   = $clog2(MAX_IT);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SQR       = 4'd1;
  localparam logic [3:0] ST_ACC       = 4'd2;
  localparam logic [3:0] ST_ROOT_INIT = 4'd3;
  localparam logic [3:0] ST_ROOT      = 4'd4;
  localparam logic [3:0] ST_RD        = 4'd5;
  localparam logic [3:0] ST_DIV_INIT  = 4'd6;
  localparam logic [3:0] ST_DIV       = 4'd7;
  localparam logic [3:0] ST_EMIT      = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic             last_r, last_nxt;
  logic             ovf_r, ovf_nxt;
  logic             oval_r, oval_nxt;
  logic             olast_r, olast_nxt;
  logic             otrunc_r, otrunc_nxt;

  assign busy            = (state_r != ST_IDLE);
  assign wr_addr         = count_r[AW-1:0];
  assign rd_addr         = idx_r[AW-1:0];
  assign out_valid       = oval_r;
  assign out_last_result = olast_r;
  assign out_truncated   = otrunc_r;

  // next-state and command decode
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    it_nxt     = it_r;
    last_nxt   = last_r;
    ovf_nxt    = ovf_r;
    oval_nxt   = 1'b0;
    olast_nxt  = olast_r;
    otrunc_nxt = otrunc_r;
    cmd        = '0;
    wr_en      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          last_nxt = in_last_element;
          if (count_r < CNT_W'(MAX_DIM)) begin
            wr_en         = 1'b1;
            cmd.load_elem = 1'b1;
            state_nxt     = ST_SQR;
          end else begin
            // store full: drop the beat, remember it
            ovf_nxt = 1'b1;
            if (in_last_element) begin
              state_nxt = ST_ROOT_INIT;
            end
          end
        end
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = last_r ? ST_ROOT_INIT : ST_IDLE;
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        it_nxt        = '0;
        idx_nxt       = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        it_nxt        = it_r + 1'b1;
        if (it_r == IT_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_elem = 1'b1;
        state_nxt   = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        it_nxt       = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        it_nxt       = it_r + 1'b1;
        if (it_r == IT_W'(vln_pkg::QUOT_BITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        oval_nxt   = 1'b1;
        otrunc_nxt = ovf_r;
        olast_nxt  = (idx_r == count_r - 1'b1);
        if (idx_r == count_r - 1'b1) begin
          // vector done: clear for the next one
          cmd.clear = 1'b1;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      it_r     <= '0;
      last_r   <= 1'b0;
      ovf_r    <= 1'b0;
      oval_r   <= 1'b0;
      olast_r  <= 1'b0;
      otrunc_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      it_r     <= it_nxt;
      last_r   <= last_nxt;
      ovf_r    <= ovf_nxt;
      oval_r   <= oval_nxt;
      olast_r  <= olast_nxt;
      otrunc_r <= otrunc_nxt;
    end
  end

endmodule

@@ rtl/vln_dp.sv @@
// Datapath: element store, squarer, sum accumulator, bit-pair square root,
// restoring divider and result register. Depends on vln_pkg and vln_ram.
`timescale 1ns / 1ps
module vln_dp #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16,
  parameter int SUM_W      = 37,
  parameter int ROOT_W     = 19,
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vln_pkg::vln_cmd_t                cmd,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [AW-1:0]                    rd_addr,
  input  logic signed [ELEM_WIDTH-1:0]     in_element,
  output logic signed [vln_pkg::OUT_W-1:0] out_unit_element
);

  localparam int EW   = ELEM_WIDTH;
  localparam int SQ_W = 2 * ROOT_W;

  logic [EW-1:0]       elem_r;
  logic [EW-1:0]       mag;
  logic [2*EW-1:0]     sq_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W:0]      sum_ext;
  logic [SQ_W-1:0]     rad_r;
  logic [ROOT_W:0]     rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [EW-1:0]       rd_data;
  logic [EW-1:0]       rd_mag;
  logic [ROOT_W:0]     drem_r;
  logic [ROOT_W:0]     dtry;
  logic                first_r;
  logic                neg_r;
  logic [vln_pkg::QUOT_BITS-1:0] quot_r;
  logic [vln_pkg::OUT_W-1:0]     quot_ext;
  logic signed [vln_pkg::OUT_W-1:0] res_r;

  // element store
  vln_ram #(.WIDTH(EW), .DEPTH(MAX_DIM)) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (in_element),
    .re      (cmd.rd_elem),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  // squarer: latch beat, then magnitude squared
  assign mag = elem_r[EW-1] ? (~elem_r + 1'b1) : elem_r;

  always_ff @(posedge clk) begin
    if (cmd.load_elem) begin
      elem_r <= in_element;
    end
    if (cmd.square) begin
      sq_r <= (2 * EW)'(mag) * (2 * EW)'(mag);
    end
  end

  // saturating sum of squares
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.clear) begin
      sum_r <= '0;
    end else if (cmd.accum) begin
      sum_r <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
  end

  // floor square root, two radicand bits per cycle; remainder can reach 2 * root
  assign rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad_r  <= SQ_W'(sum_r);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= (ROOT_W + 1)'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // restoring divide of |element| * 2^14 by the length, one bit per cycle
  assign rd_mag = rd_data[EW-1] ? (~rd_data + 1'b1) : rd_data;
  assign dtry   = first_r ? drem_r : {drem_r[ROOT_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem_r  <= (ROOT_W + 1)'(rd_mag);
      neg_r   <= rd_data[EW-1];
      first_r <= 1'b1;
      quot_r  <= '0;
    end else if (cmd.div_step) begin
      first_r <= 1'b0;
      if (dtry >= {1'b0, root_r}) begin
        drem_r <= dtry - {1'b0, root_r};
        quot_r <= {quot_r[vln_pkg::QUOT_BITS-2:0], 1'b1};
      end else begin
        drem_r <= dtry;
        quot_r <= {quot_r[vln_pkg::QUOT_BITS-2:0], 1'b0};
      end
    end
  end

  // signed result; zero length gives zero
  assign quot_ext = vln_pkg::OUT_W'(quot_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (root_r == '0) begin
        res_r <= '0;
      end else begin
        res_r <= neg_r ? (~quot_ext + 1'b1) : quot_ext;
      end
    end
  end

  assign out_unit_element = res_r;

endmodule

@@ tb/tb_vector_l2_normalizer.sv @@
// Self-checking testbench for vector_l2_normalizer: directed and random vectors,
// a predictor of the Q1.14 unit vector and an in-order result scoreboard.
// Depends on vln_pkg and the vector_l2_normalizer RTL.
`timescale 1ns / 1ps
module tb_vector_l2_normalizer;

  localparam int DIM_CAP   = 64;
  localparam int ELEM_W    = 16;
  localparam int N_ITEMS   = 370;
  localparam int SETTLE    = 60;

  typedef struct {
    logic signed [ELEM_W-1:0] elem;
    logic                     last;
    int                       phase;
    bit                       drain;
  } elem_beat_t;

  typedef struct {
    logic [vln_pkg::OUT_W-1:0] unit;
    logic                      last;
    logic                      trunc;
  } unit_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [ELEM_W-1:0] in_element = '0;
  logic in_last_element = 1'b0;
  logic busy;
  logic out_valid;
  logic signed [vln_pkg::OUT_W-1:0] out_unit_element;
  logic out_last_result;
  logic out_truncated;

  elem_beat_t   element_q[$];
  unit_result_t unit_q[$];
  elem_beat_t   cur_beat;
  int           errors = 0;

  // predictor state
  logic signed [ELEM_W-1:0] stored_elems [DIM_CAP];
  logic [63:0]              sq_total = '0;
  int                       n_stored = 0;
  bit                       dropped = 1'b0;

  // stimulus bookkeeping
  int beat_count = 0;
  int prev_phase = 0;
  bit vec_open = 1'b0;

  vector_l2_normalizer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_element       (in_element),
    .in_last_element  (in_last_element),
    .out_valid        (out_valid),
    .out_unit_element (out_unit_element),
    .out_last_result  (out_last_result),
    .out_truncated    (out_truncated)
  );

  always #4 clk = ~clk;

  // floor square root, one root bit per pass
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [63:0] mag_of(input logic signed [ELEM_W-1:0] v);
    longint sv;
    sv = v;
    return (sv < 0) ? 64'(-sv) : 64'(sv);
  endfunction

  // take one accepted beat into the predicted state; on last, queue the unit vector
  task automatic absorb_element(input elem_beat_t b);
    logic [63:0] m;
    logic [63:0] len;
    logic [63:0] q;
    logic [63:0] r;
    unit_result_t res;
    if (n_stored < DIM_CAP) begin
      m = mag_of(b.elem);
      stored_elems[n_stored] = b.elem;
      n_stored++;
      sq_total += m * m;
    end else begin
      dropped = 1'b1;
    end
    if (b.last) begin
      len = root_floor(sq_total);
      for (int k = 0; k < n_stored; k++) begin
        q = '0;
        if (len != 0) q = (mag_of(stored_elems[k]) << vln_pkg::FRAC_BITS) / len;
        r = stored_elems[k][ELEM_W-1] ? -q : q;
        res.unit  = r[vln_pkg::OUT_W-1:0];
        res.last  = (k + 1 == n_stored);
        res.trunc = dropped;
        unit_q.push_back(res);
      end
      sq_total = '0;
      n_stored = 0;
      dropped  = 1'b0;
    end
  endtask

  function automatic int idle_pct(input int phase);
    case (phase)
      0:       return 32;
      1:       return 73;
      default: return 0;
    endcase
  endfunction

  // queue one beat; the first beat of a vector fixes its phase
  task automatic add_beat(input logic signed [ELEM_W-1:0] v, input logic last);
    elem_beat_t b;
    int ph;
    b.elem  = v;
    b.last  = last;
    b.drain = 1'b0;
    if (!vec_open) begin
      ph = (beat_count < N_ITEMS / 3) ? 0 : (beat_count < 2 * N_ITEMS / 3) ? 1 : 2;
      b.drain    = (ph != prev_phase);
      prev_phase = ph;
    end
    b.phase  = prev_phase;
    vec_open = !last;
    beat_count++;
    element_q.push_back(b);
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_element();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return ELEM_W'($urandom);
    if (sel < 75) return ELEM_W'($signed($urandom_range(32)) - 16);
    if (sel < 85) begin
      case ($urandom_range(4))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        3:       return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    return ELEM_W'($signed($urandom_range(2047)) - 1024);
  endfunction

  // driver: holds a beat until taken, otherwise idles at random per phase
  always @(posedge clk) begin : drive
    bit          take;
    bit          hold_off;
    elem_beat_t  nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) absorb_element(cur_beat);
      if (start && !take) begin
        // keep the beat on the bus
      end else if (element_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        nxt = element_q[0];
        hold_off = (nxt.drain && unit_q.size() != 0) ||
                   ($urandom_range(99) < idle_pct(nxt.phase));
        if (hold_off) begin
          start <= 1'b0;
        end else begin
          cur_beat = element_q.pop_front();
          start           <= 1'b1;
          in_element      <= cur_beat.elem;
          in_last_element <= cur_beat.last;
        end
      end
    end
  end

  // monitor: every result beat against the oldest prediction
  always @(posedge clk) begin : watch
    unit_result_t exp_r;
    if (rst_n && out_valid) begin
      if (unit_q.size() == 0) begin
        $display("%0t: unexpected result beat unit=%0d last=%0b trunc=%0b",
                 $time, out_unit_element, out_last_result, out_truncated);
        errors++;
      end else begin
        exp_r = unit_q.pop_front();
        if (out_unit_element !== exp_r.unit) begin
          $display("%0t: unit_element mismatch expected %0d actual %0d",
                   $time, $signed(exp_r.unit), out_unit_element);
          errors++;
        end
        if (out_last_result !== exp_r.last) begin
          $display("%0t: last_result mismatch expected %0b actual %0b",
                   $time, exp_r.last, out_last_result);
          errors++;
        end
        if (out_truncated !== exp_r.trunc) begin
          $display("%0t: truncated mismatch expected %0b actual %0b",
                   $time, exp_r.trunc, out_truncated);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : stim
    int len;
    int sel;
    bit zero_vec;
    // directed: extremes, single elements, zero vectors, mixed signs
    add_beat(16'sh7fff, 1'b1);
    add_beat(16'sh8000, 1'b1);
    add_beat(16'sh0000, 1'b1);
    add_beat(16'sd1, 1'b1);
    add_beat(-16'sd1, 1'b1);
    add_beat(16'sd3, 1'b0);
    add_beat(16'sd4, 1'b1);
    add_beat(16'sh8000, 1'b0);
    add_beat(16'sh8000, 1'b1);
    add_beat(16'sh0000, 1'b0);
    add_beat(16'sh0000, 1'b0);
    add_beat(16'sh0000, 1'b1);
    add_beat(16'sh7fff, 1'b0);
    add_beat(16'sh8000, 1'b0);
    add_beat(16'sd1, 1'b0);
    add_beat(-16'sd1, 1'b1);
    add_beat(16'sd256, 1'b0);
    add_beat(-16'sd512, 1'b0);
    add_beat(16'sd768, 1'b1);

    // full capacity, then an overflowing vector whose last beat is dropped
    for (int i = 0; i < DIM_CAP; i++) add_beat(rand_element(), i == DIM_CAP - 1);
    for (int i = 0; i < DIM_CAP + 3; i++) add_beat(rand_element(), i == DIM_CAP + 2);

    // random vectors, mostly short
    while (beat_count < N_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 75)      len = $urandom_range(8, 1);
      else if (sel < 90) len = $urandom_range(32, 9);
      else if (sel < 95) len = $urandom_range(64, 33);
      else               len = $urandom_range(70, 65);
      zero_vec = ($urandom_range(99) < 5);
      for (int i = 0; i < len; i++)
        add_beat(zero_vec ? '0 : rand_element(), i == len - 1);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (element_q.size() != 0 || start || unit_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (unit_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, unit_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
